FILE: rtl/core/mdw_pkg.sv
`timescale 1ns / 1ps

package mdw_pkg;

  localparam int VALUE_W            = 14;
  localparam int SUM_OUT_W          = 27;
  localparam int VALUE_BITS_DEF     = 14;
  localparam int WINDOW_DEPTH_DEF   = 16384;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_last;
  } in_item_t;

  typedef struct packed {
    logic [SUM_OUT_W-1:0] best_sum;
    logic [SUM_OUT_W-1:0] window_sum;
    logic                 done_res;
  } out_item_t;

endpackage

FILE: rtl/core/mdw_ram.sv
`timescale 1ns / 1ps

module mdw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/max_sum_distinct_window.sv
`timescale 1ns / 1ps

// Maximum-sum window of distinct values.
// in_data carries one value and an is_last flag per item; out_data returns one
// result per item: best window sum of the sequence so far, current window sum,
// and done_res (a copy of is_last). Both channels use valid/stall; an item moves
// on an edge where valid is high and stall is low.
// The window lives in a ring RAM with a presence bitmap RAM indexed by value;
// one read port per RAM and a small sequencer do all the work, one item at a time.
// Per item: accept, bitmap lookup, an evict step per evicted entry, then append,
// which loads the output register. out_valid rises on the edge that leaves
// the append step, and for an item not flagged last in_stall drops on that
// same edge; a new item is taken only once the last one's result is registered.
// After an item flagged last, the window is drained at one entry per cycle
// and the sums restart from zero.
// After reset the bitmap is cleared by a pass over all 2^VALUE_BITS entries
// (16384 by default), during which in_stall stays high.
// When the receiver stalls, the result holds in the output register; the block
// waits in its append step only if a second result is ready before the first
// one is taken.

module max_sum_distinct_window
  import mdw_pkg::*;
#(
  parameter int VALUE_BITS   = VALUE_BITS_DEF,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int RING_AW  = $clog2(WINDOW_DEPTH);
  localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_BITS = 2 * VALUE_BITS;
  localparam int MAP_SIZE = 1 << VALUE_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_EVICT, ST_APPEND, ST_DRAIN_RD, ST_DRAIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_BITS-1:0]  clr_r, clr_nxt;
  logic [VALUE_BITS-1:0]  v_r, v_nxt;
  logic                   last_r, last_nxt;
  logic                   dup_r, dup_nxt;
  logic [RING_AW-1:0]     head_r, head_nxt;
  logic [RING_AW-1:0]     tail_r, tail_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [SUM_BITS-1:0]    best_r, best_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic                   map_we;
  logic [VALUE_BITS-1:0]  map_waddr;
  logic                   map_wdata;
  logic [VALUE_BITS-1:0]  map_raddr;
  logic                   map_q;

  logic                   ring_we;
  logic [RING_AW-1:0]     ring_raddr;
  logic [VALUE_BITS-1:0]  ring_q;

  logic [RING_AW-1:0]     head_adv, tail_adv;
  logic [SUM_BITS-1:0]    sum_add;
  logic                   out_free;

  assign head_adv  = (head_r == RING_AW'(WINDOW_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_adv  = (tail_r == RING_AW'(WINDOW_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign sum_add   = sum_r + SUM_BITS'(v_r);
  assign out_free  = !out_valid_r || !out_stall;

  assign map_raddr  = VALUE_BITS'(in_data.value);
  // evict and drain keep the next read one entry ahead of the one retiring
  assign ring_raddr = (state_r == ST_EVICT || state_r == ST_DRAIN) ? head_adv : head_r;
  assign ring_we    = (state_r == ST_APPEND) && out_free;

  mdw_ram #(
    .WIDTH (1),
    .DEPTH (MAP_SIZE),
    .AW    (VALUE_BITS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_q)
  );

  mdw_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (WINDOW_DEPTH),
    .AW    (RING_AW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (tail_r),
    .wdata (v_r),
    .raddr (ring_raddr),
    .rdata (ring_q)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    v_nxt         = v_r;
    last_nxt      = last_r;
    dup_nxt       = dup_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    map_we        = 1'b0;
    map_waddr     = ring_q;
    map_wdata     = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          v_nxt     = VALUE_BITS'(in_data.value);
          last_nxt  = in_data.is_last;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (map_q && fill_r != '0) begin
          dup_nxt   = 1'b1;
          state_nxt = ST_EVICT;
        end else if (fill_r == FILL_W'(WINDOW_DEPTH)) begin
          dup_nxt   = 1'b0;
          state_nxt = ST_EVICT;
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_EVICT: begin
        // ring_q holds the oldest entry
        map_we   = 1'b1;
        sum_nxt  = sum_r - SUM_BITS'(ring_q);
        head_nxt = head_adv;
        fill_nxt = fill_r - 1'b1;
        // values in the window are distinct: once the duplicate leaves, stop (a full window drops one entry)
        if (!dup_r || ring_q == v_r) begin
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: begin
        if (out_free) begin
          map_we                  = 1'b1;
          map_waddr               = v_r;
          map_wdata               = 1'b1;
          tail_nxt                = tail_adv;
          fill_nxt                = fill_r + 1'b1;
          sum_nxt                 = sum_add;
          best_nxt                = (sum_add > best_r) ? sum_add : best_r;
          out_valid_nxt           = 1'b1;
          out_data_nxt.best_sum   = SUM_OUT_W'((sum_add > best_r) ? sum_add : best_r);
          out_data_nxt.window_sum = SUM_OUT_W'(sum_add);
          out_data_nxt.done_res   = last_r;
          state_nxt               = last_r ? ST_DRAIN_RD : ST_IDLE;
        end
      end
      ST_DRAIN_RD: begin
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        map_we   = 1'b1;
        head_nxt = head_adv;
        fill_nxt = fill_r - 1'b1;
        if (fill_r == FILL_W'(1)) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          sum_nxt   = '0;
          best_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
      v_r         <= v_nxt;
      last_r      <= last_nxt;
      dup_r       <= dup_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import mdw_pkg::*;

  localparam int MAP_SIZE = 1 << VALUE_BITS_DEF;
  localparam int RING_SIZE = WINDOW_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1550;

  // Predicts one result per item: best and current distinct-window sums.
  class distinct_window_model;
    bit                 seen [MAP_SIZE];
    logic [VALUE_W-1:0] ring [RING_SIZE];
    int unsigned        head, tail, fill;
    longint unsigned    win_sum, best;
    out_item_t          sums_due [$];
    int unsigned        errors, matched, widest;

    function new();
      foreach (seen[i]) seen[i] = 1'b0;
      head = 0;
      tail = 0;
      fill = 0;
      win_sum = 0;
      best = 0;
      errors = 0;
      matched = 0;
      widest = 0;
    endfunction

    function void drop_oldest();
      logic [VALUE_W-1:0] old;
      if (fill == 0) return;
      old = ring[head];
      seen[old] = 1'b0;
      win_sum -= old;
      head = (head + 1) % RING_SIZE;
      fill--;
    endfunction

    function void take_value(in_item_t it);
      int unsigned v;
      out_item_t   e;
      v = it.value % MAP_SIZE;
      while (seen[v] && fill > 0) drop_oldest();
      // only reachable when the ring is shallower than the value space
      if (fill >= RING_SIZE) drop_oldest();
      ring[tail] = VALUE_W'(v);
      tail = (tail + 1) % RING_SIZE;
      fill++;
      seen[v] = 1'b1;
      win_sum += v;
      if (win_sum > best) best = win_sum;
      if (fill > widest) widest = fill;
      e.best_sum = SUM_OUT_W'(best);
      e.window_sum = SUM_OUT_W'(win_sum);
      e.done_res = it.is_last;
      sums_due.push_back(e);
      if (it.is_last) begin
        while (fill > 0) drop_oldest();
        head = 0;
        tail = 0;
        win_sum = 0;
        best = 0;
      end
    endfunction

    function void match_result(out_item_t got);
      out_item_t e;
      if (sums_due.size() == 0) begin
        $error("unexpected result: best_sum %0d window_sum %0d done_res %0d",
               got.best_sum, got.window_sum, got.done_res);
        errors++;
        return;
      end
      e = sums_due.pop_front();
      matched++;
      if (got.best_sum !== e.best_sum) begin
        $error("best_sum: expected %0d, actual %0d", e.best_sum, got.best_sum);
        errors++;
      end
      if (got.window_sum !== e.window_sum) begin
        $error("window_sum: expected %0d, actual %0d", e.window_sum, got.window_sum);
        errors++;
      end
      if (got.done_res !== e.done_res) begin
        $error("done_res: expected %0d, actual %0d", e.done_res, got.done_res);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  distinct_window_model sb = new();
  bit          quiet = 1'b0;
  int unsigned items_sent = 0;
  int unsigned sequences = 0;

  max_sum_distinct_window dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(input logic [VALUE_W-1:0] value, input bit last);
    int       gap;
    in_item_t it;
    gap = quiet ? 0 : $urandom_range(0, 12);
    it.value = value;
    it.is_last = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.take_value(it);
    items_sent++;
    if (last) sequences++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.sums_due.size() != 0) @(posedge clk);
  endtask

  // receiver
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.match_result(out_data);
    end
  end

  initial begin
    int                 kind, len, pool, base_v;
    bit                 paused;
    logic [VALUE_W-1:0] v;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero, repeats at head, middle and tail, lone items
    send_item(16383, 0);
    send_item(1, 0);
    send_item(0, 0);
    send_item(8192, 0);
    send_item(1, 0);
    send_item(5, 1);
    send_item(16383, 1);
    send_item(0, 0);
    send_item(0, 1);
    send_item(7, 0);
    send_item(7, 0);
    send_item(7, 1);
    send_item(3, 0);
    send_item(5, 0);
    send_item(3, 0);
    send_item(9, 0);
    send_item(5, 1);
    send_item(16000, 0);
    send_item(16001, 0);
    send_item(16382, 0);
    send_item(16383, 0);
    send_item(16382, 1);
    send_item(1, 1);
    drain_results();

    while (items_sent < RANDOM_ITEMS + 23) begin
      quiet = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      pool = $urandom_range(2, 64);
      base_v = $urandom_range(0, MAP_SIZE - 1);
      case (kind)
        0: len = $urandom_range(1, 8);
        7: begin
          len = $urandom_range(100, 300);
          pool = 512;
        end
        8: len = 1;
        9: len = $urandom_range(2, 6);
        default: len = $urandom_range(1, 80);
      endcase
      for (int i = 0; i < len; i++) begin
        if (kind == 0 || kind == 8)
          v = $urandom_range(0, MAP_SIZE - 1);
        else if (kind == 9)
          v = VALUE_W'(base_v);
        else if ($urandom_range(0, 39) == 0)
          v = '0;
        else
          v = VALUE_W'((base_v + $urandom_range(0, pool - 1)) % MAP_SIZE);
        send_item(v, i == len - 1);
      end
      if (!paused && items_sent >= 800) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (64) @(posedge clk);
    $display("%0d items in %0d sequences, %0d results checked, widest window %0d",
             items_sent, sequences, sb.matched, sb.widest);
    if (sb.errors == 0 && sb.sums_due.size() == 0)
      $display("max_sum_distinct_window regression: pass");
    else
      $display("max_sum_distinct_window regression: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("max_sum_distinct_window regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/mdw_pkg.sv
rtl/core/mdw_ram.sv
rtl/core/max_sum_distinct_window.sv
dv/tb.sv
